// ===== rtl/bgts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgts_pkg
// Shared types and codes of the guarded transition step block: commands,
// classified operations, result kinds and the result record.
// ----------------------------------------------------------------------------
package bgts_pkg;

  // Input command codes, carried on the input tuser.
  typedef enum logic [1:0] {
    CMD_STATE_WR = 2'd0,
    CMD_ENTRY_WR = 2'd1,
    CMD_STEP     = 2'd2
  } cmd_t;

  // Operation classes handed from the front to the back.
  typedef enum logic [1:0] {
    OP_STATE_WR = 2'd0,
    OP_ENTRY_WR = 2'd1,
    OP_STEP     = 2'd2,
    OP_BAD_SRC  = 2'd3
  } op_kind_t;

  // Result kinds, carried on the output tuser.
  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_MATCH   = 2'd1,
    KIND_NOMATCH = 2'd2,
    KIND_BADSRC  = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam logic CFG_ACTIVE_STATES = 1'b0;
  localparam logic CFG_GROUP_BASE    = 1'b1;

  localparam logic [6:0] ACTIVE_STATES_RESET = 7'd1;

  // A step gives at most this many matches.
  localparam int MAX_MATCHES = 16;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INFO,
    ST_SCAN,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    op_kind_t    kind;
    logic        wr_ok;
    logic [5:0]  src;
    logic [3:0]  slot;
    logic        accept_bit;
    logic [4:0]  slot_cnt;
    logic [29:0] pos_mask;
    logic [29:0] neg_mask;
    logic [5:0]  dest_state;
    logic [9:0]  trans_index;
    logic [29:0] pred_mask;
  } op_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  next_state;
    logic [14:0] group;
    logic        source_accept;
    logic [4:0]  match_number;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/bgts_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgts_front
// Accept input beats, unpack them and classify each into an operation for
// the back end; range-check writes and step sources, drop unknown commands.
// ----------------------------------------------------------------------------
module bgts_front #(
  parameter int STATES = 64,
  parameter int SLOTS  = 16
) (
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [127:0]       s_tdata,
  input  wire logic [1:0]         s_tuser,
  input  wire logic [6:0]         active_states,
  input  wire logic               clearing,
  input  wire logic               q_full,
  output logic                    push,
  output bgts_pkg::op_t           op
);

  logic [5:0] sel;
  logic       pre;
  logic [3:0] slot;
  logic [4:0] tcnt;
  logic [5:0] src;
  logic       take;

  assign sel  = s_tdata[5:0];
  assign pre  = s_tdata[6];
  assign slot = s_tdata[10:7];
  assign tcnt = s_tdata[16:12];
  assign src  = pre ? 6'd0 : sel;

  // Hold off while the queue is full or the state table is being cleared.
  assign s_tready = !q_full && !clearing && !rst;
  assign take     = s_tvalid && s_tready;

  always_comb begin
    op.kind        = bgts_pkg::OP_STEP;
    op.wr_ok       = 1'b0;
    op.src         = sel;
    op.slot        = slot;
    op.accept_bit  = s_tdata[11];
    op.slot_cnt    = (32'(tcnt) > SLOTS) ? 5'(SLOTS) : tcnt;
    op.pos_mask    = s_tdata[46:17];
    op.neg_mask    = s_tdata[76:47];
    op.dest_state  = s_tdata[82:77];
    op.trans_index = s_tdata[92:83];
    op.pred_mask   = s_tdata[122:93];
    push           = 1'b0;
    unique case (bgts_pkg::cmd_t'(s_tuser))
      bgts_pkg::CMD_STATE_WR: begin
        op.kind  = bgts_pkg::OP_STATE_WR;
        op.wr_ok = 32'(sel) < STATES;
        push     = take;
      end
      bgts_pkg::CMD_ENTRY_WR: begin
        op.kind  = bgts_pkg::OP_ENTRY_WR;
        op.wr_ok = (32'(sel) < STATES) && (32'(slot) < SLOTS);
        push     = take;
      end
      bgts_pkg::CMD_STEP: begin
        // Map the pre-initial source to state 0; flag any source at or beyond the states in use.
        op.src = src;
        if (({1'b0, src} >= active_states) || (32'(src) >= STATES)) begin
          op.kind = bgts_pkg::OP_BAD_SRC;
        end else begin
          op.kind = bgts_pkg::OP_STEP;
        end
        push = take;
      end
      default: begin
        // Unknown command: accept and drop.
        push = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bgts_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgts_queue
// Two-entry operation queue between the front and the back end.
// ----------------------------------------------------------------------------
module bgts_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire bgts_pkg::op_t push_op,
  output logic               full,
  output logic               q_valid,
  output bgts_pkg::op_t      q_op,
  input  wire logic          pop
);

  localparam logic [1:0] DEPTH = 2'd2;

  bgts_pkg::op_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign full    = count == DEPTH;
  assign q_valid = count != 2'd0;
  assign q_op    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bgts_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgts_back
// Execute queued operations: own the state and transition tables, scan one
// slot per cycle on a step unless output stalls, and drive the result register.
// ----------------------------------------------------------------------------
module bgts_back #(
  parameter int STATES    = 64,
  parameter int SLOTS     = 16,
  parameter int PRED_BITS = 30
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [14:0]   group_base,
  output logic               clearing,
  input  wire logic          q_valid,
  input  wire bgts_pkg::op_t q_op,
  output logic               pop,
  output logic               out_valid,
  output bgts_pkg::res_t     out_res,
  input  wire logic          out_ready
);

  localparam int SW = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int JW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int AW = (STATES * SLOTS > 1) ? $clog2(STATES * SLOTS) : 1;
  localparam int PW = PRED_BITS;
  localparam int EW = 2 * PW + 16;
  localparam int ENTRIES = STATES * SLOTS;

  // State table: {accept, slot count}. Transition table: {index, dest, neg, pos}.
  logic [CW:0]   smem [STATES];
  logic [EW-1:0] emem [ENTRIES];

  logic          smem_we;
  logic [SW-1:0] smem_waddr;
  logic [CW:0]   smem_wdata;
  logic          smem_re;
  logic [CW:0]   smem_rd;
  logic          emem_we;
  logic [AW-1:0] emem_waddr;
  logic [EW-1:0] emem_wdata;
  logic          emem_re;
  logic [AW-1:0] emem_raddr;
  logic [EW-1:0] emem_rd;

  bgts_pkg::seq_state_t state;
  bgts_pkg::seq_state_t state_next;

  logic [SW-1:0] clr_idx;
  logic [SW-1:0] src;
  logic [JW-1:0] j;
  logic [4:0]    k;
  logic          pend_valid;
  logic [5:0]    pend_next;
  logic [14:0]   pend_group;
  logic [4:0]    pend_num;

  logic           out_free;
  logic           emit;
  bgts_pkg::res_t emit_res;
  logic           start_step;
  logic           scan_adv;
  logic           scan_end;
  logic           hit;
  logic [AW-1:0]  ebase;
  logic [PW-1:0]  pred;
  logic [PW-1:0]  e_pos;
  logic [PW-1:0]  e_neg;
  logic           s_acc;
  logic [CW-1:0]  s_cnt;
  logic [CW-1:0]  op_cnt;

  assign out_free = !out_valid || out_ready;
  assign clearing = state == bgts_pkg::ST_CLEAR;
  assign ebase    = AW'(src) * AW'(SLOTS);
  assign pred     = PW'(q_op.pred_mask);
  assign e_pos    = emem_rd[PW-1:0];
  assign e_neg    = emem_rd[2*PW-1:PW];
  assign s_acc    = smem_rd[CW];
  assign s_cnt    = smem_rd[CW-1:0];
  assign op_cnt   = CW'(q_op.slot_cnt);

  // The step op stays at the queue head until the step ends, so its
  // predicate mask is read from there throughout the scan.
  assign hit = ((pred & e_pos) == e_pos) && ((pred & e_neg) == '0);

  always_ff @(posedge clk) begin
    if (smem_we) begin
      smem[smem_waddr] <= smem_wdata;
    end
    if (smem_re) begin
      smem_rd <= smem[SW'(q_op.src)];
    end
  end

  always_ff @(posedge clk) begin
    if (emem_we) begin
      emem[emem_waddr] <= emem_wdata;
    end
    if (emem_re) begin
      emem_rd <= emem[emem_raddr];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bgts_pkg::ST_CLEAR: begin
        if (clr_idx == SW'(STATES - 1)) begin
          state_next = bgts_pkg::ST_IDLE;
        end
      end
      bgts_pkg::ST_IDLE: begin
        if (start_step) begin
          state_next = bgts_pkg::ST_INFO;
        end
      end
      bgts_pkg::ST_INFO: begin
        state_next = (s_cnt == '0) ? bgts_pkg::ST_DONE : bgts_pkg::ST_SCAN;
      end
      bgts_pkg::ST_SCAN: begin
        if (scan_adv && scan_end) begin
          state_next = bgts_pkg::ST_DONE;
        end
      end
      bgts_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = bgts_pkg::ST_IDLE;
        end
      end
      default: state_next = bgts_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop        = 1'b0;
    start_step = 1'b0;
    emit       = 1'b0;
    emit_res   = '{kind: bgts_pkg::KIND_ACK, next_state: '0, group: '0,
                   source_accept: 1'b0, match_number: '0, last: 1'b1};
    smem_we    = 1'b0;
    smem_waddr = SW'(q_op.src);
    smem_wdata = {q_op.accept_bit, op_cnt};
    smem_re    = 1'b0;
    emem_we    = 1'b0;
    emem_waddr = AW'(SW'(q_op.src)) * AW'(SLOTS) + AW'(JW'(q_op.slot));
    emem_wdata = {q_op.trans_index, q_op.dest_state,
                  PW'(q_op.neg_mask), PW'(q_op.pos_mask)};
    emem_re    = 1'b0;
    emem_raddr = ebase;
    scan_adv   = 1'b0;
    scan_end   = 1'b0;
    unique case (state)
      bgts_pkg::ST_CLEAR: begin
        smem_we    = 1'b1;
        smem_waddr = clr_idx;
        smem_wdata = '0;
      end
      bgts_pkg::ST_IDLE: begin
        if (q_valid && out_free) begin
          unique case (q_op.kind)
            bgts_pkg::OP_STATE_WR: begin
              pop     = 1'b1;
              emit    = 1'b1;
              smem_we = q_op.wr_ok;
            end
            bgts_pkg::OP_ENTRY_WR: begin
              pop     = 1'b1;
              emit    = 1'b1;
              emem_we = q_op.wr_ok;
            end
            bgts_pkg::OP_BAD_SRC: begin
              pop           = 1'b1;
              emit          = 1'b1;
              emit_res.kind = bgts_pkg::KIND_BADSRC;
            end
            bgts_pkg::OP_STEP: begin
              // Keep the op at the head; read the source state next cycle.
              start_step = 1'b1;
            end
            default: ;
          endcase
        end
      end
      bgts_pkg::ST_INFO: begin
        smem_re    = 1'b0;
        emem_re    = 1'b1;
        emem_raddr = ebase;
      end
      bgts_pkg::ST_SCAN: begin
        // A second hit pushes the held one out, which needs the result slot.
        scan_adv = !(hit && pend_valid) || out_free;
        scan_end = (CW'(j) == s_cnt - CW'(1)) ||
                   (hit && (k == 5'(bgts_pkg::MAX_MATCHES - 1)));
        if (scan_adv) begin
          emit       = hit && pend_valid;
          emem_re    = !scan_end;
          emem_raddr = ebase + AW'(j) + AW'(1);
        end
        emit_res = '{kind: bgts_pkg::KIND_MATCH, next_state: pend_next,
                     group: pend_group, source_accept: s_acc,
                     match_number: pend_num, last: 1'b0};
      end
      bgts_pkg::ST_DONE: begin
        emit = out_free;
        pop  = out_free;
        if (pend_valid) begin
          emit_res = '{kind: bgts_pkg::KIND_MATCH, next_state: pend_next,
                       group: pend_group, source_accept: s_acc,
                       match_number: pend_num, last: 1'b1};
        end else begin
          emit_res = '{kind: bgts_pkg::KIND_NOMATCH, next_state: '0, group: '0,
                       source_accept: s_acc, match_number: '0, last: 1'b1};
        end
      end
      default: ;
    endcase
    if (start_step) begin
      smem_re = 1'b1;
    end
  end

  // Source index is latched in the idle state; the transition reads use it,
  // while the state read takes the head's source directly at start.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bgts_pkg::ST_CLEAR;
      clr_idx    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + SW'(1);
      end
      if (state == bgts_pkg::ST_INFO) begin
        pend_valid <= 1'b0;
      end else if (state == bgts_pkg::ST_SCAN && scan_adv && hit) begin
        pend_valid <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res <= emit_res;
    end
    if (state == bgts_pkg::ST_IDLE) begin
      src <= SW'(q_op.src);
    end
    if (state == bgts_pkg::ST_INFO) begin
      j <= '0;
      k <= '0;
    end else if (state == bgts_pkg::ST_SCAN && scan_adv) begin
      j <= j + JW'(1);
      if (hit) begin
        k          <= k + 5'd1;
        pend_next  <= emem_rd[2*PW+5:2*PW];
        pend_group <= group_base + 15'(emem_rd[2*PW+15:2*PW+6]);
        pend_num   <= k + 5'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/buchi_guarded_transition_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buchi_guarded_transition_step
// Transition table of a Buchi automaton with guarded transitions: load
// commands fill it, a step command emits every transition whose guard holds.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_tvalid/s_tready with the command on s_tuser
//   (0 write state info, 1 write transition entry, 2 step). Every load gives
//   one acknowledge beat; a step gives one beat per matching slot in slot
//   order (last one with m_tlast set), or one no-match beat, or one bad-source
//   beat. Command 3 is taken and dropped.
//   Sequence: a load or a bad-source step passes through the queue and
//   then the result register. A good step starts, reads the state info,
//   takes one slot a cycle out of the transition memory read port unless
//   the output stalls, and then closes; the next item starts after that.
//   Reset: synchronous; afterwards the state table is swept clear, one state
//   a cycle through all STATES entries, while s_tready stays low. Configuration
//   writes on cfg_we/cfg_index/cfg_data are taken whenever rst is low.
//   Stall: a held result waits in the output register; a two-beat queue lets
//   the front keep taking items while the back end waits on m_tready.
// ----------------------------------------------------------------------------
module buchi_guarded_transition_step #(
  parameter int STATES    = 64,
  parameter int SLOTS     = 16,
  parameter int PRED_BITS = 30
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Fields from bit 0 up: state_sel[5:0], pre_initial[6], slot[10:7],
  // accept_bit[11], slot_cnt[16:12], pos_mask[46:17], neg_mask[76:47],
  // dest_state[82:77], trans_index[92:83], pred_mask[122:93], zero fill.
  input  wire logic [127:0] s_tdata,
  // Fields: cmd[1:0].
  input  wire logic [1:0]   s_tuser,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // Fields from bit 0 up: next_state[5:0], group[20:6], source_accept[21],
  // match_number[26:22], zero fill.
  output logic [31:0]       m_tdata,
  // Fields: kind[1:0].
  output logic [1:0]        m_tuser,
  output logic              m_tlast,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [14:0]  cfg_data
);

  logic [6:0]     active_states;
  logic [14:0]    group_base;
  logic           clearing;
  logic           q_full;
  logic           push;
  bgts_pkg::op_t  push_op;
  logic           q_valid;
  bgts_pkg::op_t  q_op;
  logic           pop;
  bgts_pkg::res_t res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_states <= bgts_pkg::ACTIVE_STATES_RESET;
      group_base    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgts_pkg::CFG_ACTIVE_STATES: active_states <= cfg_data[6:0];
        bgts_pkg::CFG_GROUP_BASE:    group_base    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: unpack and classify each beat.
  bgts_front #(
    .STATES(STATES),
    .SLOTS (SLOTS)
  ) u_front (
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .active_states(active_states),
    .clearing     (clearing),
    .q_full       (q_full),
    .push         (push),
    .op           (push_op)
  );

  // Decouple the front from the back end.
  bgts_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .full   (q_full),
    .q_valid(q_valid),
    .q_op   (q_op),
    .pop    (pop)
  );

  // Back end: tables, slot scan and result register.
  bgts_back #(
    .STATES   (STATES),
    .SLOTS    (SLOTS),
    .PRED_BITS(PRED_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .group_base(group_base),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_res   (res),
    .out_ready (m_tready)
  );

  // Pack the result beat.
  assign m_tdata = {5'd0, res.match_number, res.source_accept, res.group,
                    res.next_state};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule
`default_nettype wire
